// File: rtl/core/sbrh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbrh_pkg: shared types and constants for the seed byte rotate and hash block
// Holds the transfer payload structs, the cell link struct and pipeline sizes.
// ----------------------------------------------------------------------------
package sbrh_pkg;

	localparam int BYTE_W      = 8;
	localparam int NUM_CELLS   = 8;
	localparam int SEED_W      = BYTE_W * NUM_CELLS;
	localparam int HASH_W      = 32;
	localparam int CELL_STAGES = 2;
	localparam int HASH_STAGES = 4;
	localparam int PIPE_LAT    = CELL_STAGES * NUM_CELLS + HASH_STAGES;

	typedef struct packed {
		logic [SEED_W-1:0] seed_value;
		logic [BYTE_W-1:0] level_depth;
		logic [BYTE_W-1:0] orient_code;
	} item_t;

	typedef struct packed {
		logic [SEED_W-1:0] rotated_seed;
		logic [HASH_W-1:0] seed_hash;
	} result_t;

	// Data handed from one cell to the next
	typedef struct packed {
		logic              valid;
		logic [SEED_W-1:0] word;
		logic [BYTE_W-1:0] step;
		logic [BYTE_W-1:0] orient;
	} link_t;

endpackage
`default_nettype wire

// File: rtl/core/sbrh_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbrh_cell: one byte cell of the rotation chain
// Adds the step to the low byte, reduces orient modulo that byte over two
// stages, rotates the word one byte right with the new byte on top.
// ----------------------------------------------------------------------------
module sbrh_cell
	import sbrh_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire link_t lnk_in,
	output link_t      lnk_out
);

	localparam int HALF = BYTE_W / 2;

	// One restoring step; a zero divisor leaves the dividend bits untouched,
	// so orient mod zero comes out as orient itself.
	function automatic logic [BYTE_W-1:0] rem_step(
		input logic [BYTE_W-1:0] rem,
		input logic              din,
		input logic [BYTE_W-1:0] dvs
	);
		logic [BYTE_W:0] sh;
		sh = {rem, din};
		if (sh >= {1'b0, dvs}) begin
			sh = sh - {1'b0, dvs};
		end
		return sh[BYTE_W-1:0];
	endfunction

	logic [BYTE_W-1:0] sum_b;
	logic [BYTE_W-1:0] rem_a;
	logic [BYTE_W-1:0] rem_b;

	logic              vld_s1;
	logic [SEED_W-1:0] word_s1;
	logic [BYTE_W-1:0] step_s1;
	logic [BYTE_W-1:0] orient_s1;
	logic [BYTE_W-1:0] div_s1;
	logic [BYTE_W-1:0] rem_s1;

	logic              vld_s2;
	logic [SEED_W-1:0] word_s2;
	logic [BYTE_W-1:0] step_s2;
	logic [BYTE_W-1:0] orient_s2;

	always_comb begin
		sum_b = lnk_in.word[BYTE_W-1:0] + lnk_in.step;
		rem_a = '0;
		for (int i = BYTE_W - 1; i >= HALF; i--) begin
			rem_a = rem_step(rem_a, lnk_in.orient[i], sum_b);
		end
	end

	always_comb begin
		rem_b = rem_s1;
		for (int i = HALF - 1; i >= 0; i--) begin
			rem_b = rem_step(rem_b, orient_s1[i], div_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= lnk_in.valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		word_s1   <= {sum_b, lnk_in.word[SEED_W-1:BYTE_W]};
		step_s1   <= lnk_in.step;
		orient_s1 <= lnk_in.orient;
		div_s1    <= sum_b;
		rem_s1    <= rem_a;
		word_s2   <= word_s1;
		step_s2   <= step_s1 + rem_b;
		orient_s2 <= orient_s1;
	end

	assign lnk_out = '{valid: vld_s2, word: word_s2, step: step_s2, orient: orient_s2};

endmodule
`default_nettype wire

// File: rtl/core/sbrh_hash.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbrh_hash: four-stage 64-to-32 bit integer hash
// Invert-and-shift, xor-shift, times 21 as shifted adds, xor-shift,
// add-shift, xor-shift; one wide add per stage.
// ----------------------------------------------------------------------------
module sbrh_hash
	import sbrh_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              vld_in,
	input  wire logic [SEED_W-1:0] key,
	output logic                   vld_out,
	output result_t                res
);

	localparam int SH_A = 18;
	localparam int SH_B = 31;
	localparam int SH_C = 11;
	localparam int SH_D = 6;
	localparam int SH_E = 22;

	logic [SEED_W-1:0] x2;
	logic [SEED_W-1:0] t3;
	logic [SEED_W-1:0] t4;

	logic              vld_s1, vld_s2, vld_s3, vld_s4;
	logic [SEED_W-1:0] key_s1, key_s2, key_s3, key_s4;
	logic [SEED_W-1:0] t_s1;
	logic [SEED_W-1:0] x_s2;
	logic [SEED_W-1:0] m_s2;
	logic [SEED_W-1:0] t_s3;
	logic [SEED_W-1:0] t_s4;

	always_comb begin
		x2 = t_s1 ^ (t_s1 >> SH_B);
		t3 = m_s2 + (x_s2 << 4);
		t4 = t_s3 + (t_s3 << SH_D);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		key_s1 <= key;
		t_s1   <= (~key) + (key << SH_A);
		key_s2 <= key_s1;
		x_s2   <= x2;
		m_s2   <= x2 + (x2 << 2);
		key_s3 <= key_s2;
		t_s3   <= t3 ^ (t3 >> SH_C);
		key_s4 <= key_s3;
		t_s4   <= t4 ^ (t4 >> SH_E);
	end

	assign vld_out = vld_s4;
	assign res     = '{rotated_seed: key_s4, seed_hash: t_s4[HASH_W-1:0]};

endmodule
`default_nettype wire

// File: rtl/core/seed_byte_rotate_and_hash_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seed_byte_rotate_and_hash_top: byte-wise seed rotation followed by a hash
// A chain of eight byte cells feeding a four-stage integer hash pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive item and raise start; a transfer happens at every
//   rising edge with start high and busy low. busy stays low, so a new seed
//   can be issued on every cycle.
//   Result channel: done pulses for one cycle with result (rotated seed and
//   32-bit hash). Results come back in issue order, one per command.
//   Path: a command passes through each byte cell in turn (add plus modulo
//   in two halves), then through the hash stages, whose last register
//   holds the result. Throughput: one seed per cycle, set by the fully
//   pipelined cell chain.
//   Each cell handles the low byte of its word and rotates the word one byte
//   right, so after eight cells the bytes are back in their original order.
//   The receiver cannot stall: a result is shown for exactly one cycle.
//   Reset (arst_n low) drops every item in flight; no done pulses follow
//   for commands issued before reset.
// ----------------------------------------------------------------------------
module seed_byte_rotate_and_hash_top
	import sbrh_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	output logic       busy,
	input  wire item_t item,
	output logic       done,
	output result_t    result
);

	link_t lnk [0:NUM_CELLS];

	// Fully pipelined: never hold off a command
	assign busy = 1'b0;

	// Seed the chain with the starting step and orientation
	assign lnk[0] = '{valid:  start && !busy,
	                  word:   item.seed_value,
	                  step:   item.level_depth,
	                  orient: item.orient_code};

	// Advance one byte per cell
	for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
		sbrh_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.lnk_in (lnk[g]),
			.lnk_out(lnk[g+1])
		);
	end

	// Hash the rotated word; its last stage is the result register
	sbrh_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_in (lnk[NUM_CELLS].valid),
		.key    (lnk[NUM_CELLS].word),
		.vld_out(done),
		.res    (result)
	);

endmodule
`default_nettype wire

// File: rtl/core/sbrh_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbrh_chk: port-level checker for the seed rotate and hash block
// Checks fixed latency, one result per command and determinism of results.
// ----------------------------------------------------------------------------
module sbrh_chk
	import sbrh_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    start,
	input wire logic    busy,
	input wire item_t   item,
	input wire logic    done,
	input wire result_t result
);

	// The pipeline never holds off a command
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

	// Every command transfer yields a result after the fixed latency
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_LAT done)
		else $error("result missing after command transfer");

	// No result without a command transfer the fixed latency earlier
	a_no_stray_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LAT))
		else $error("result without matching command");

	// Back-to-back equal commands give equal results
	a_deterministic: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(done) &&
		 ($past(item, PIPE_LAT) == $past(item, PIPE_LAT + 1)))
		|-> (result == $past(result)))
		else $error("equal commands gave different results");

endmodule

bind seed_byte_rotate_and_hash_top sbrh_chk u_sbrh_chk (.*);
`default_nettype wire
